// ===== design/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition implies another in the same cycle.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Checks that a condition implies another in the following cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== design/aavr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package aavr_pkg;

    localparam int COORD_WIDTH      = 32;
    localparam int MATRIX_FRAC_BITS = 16;
    localparam int ROT_WIDTH        = 20;
    localparam int CFG_INDEX_WIDTH  = 2;
    localparam int CORDIC_STEPS     = 16;
    localparam int CORDIC_GAIN      = 652032874;
    localparam int PI_Q24           = 52707179;
    localparam int HALF_PI_Q24      = 26353589;
    localparam int TWO_PI_Q24       = 105414357;

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_ROT_X = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_ROT_Y = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_ROT_Z = 2'd2;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] vertex_x;
        logic signed [COORD_WIDTH-1:0] vertex_y;
        logic signed [COORD_WIDTH-1:0] vertex_z;
    } vertex_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] out_x;
        logic signed [COORD_WIDTH-1:0] out_y;
        logic signed [COORD_WIDTH-1:0] out_z;
    } result_t;

    typedef struct packed {
        logic ready;
        logic pass_through;
    } mat_status_t;

    // Arctangent of 2^-i in Q.16.
    function automatic logic [15:0] atan_q16(input logic [3:0] i);
        logic [15:0] v;
        case (i)
            4'd0:    v = 16'd51472;
            4'd1:    v = 16'd30386;
            4'd2:    v = 16'd16055;
            4'd3:    v = 16'd8150;
            4'd4:    v = 16'd4091;
            4'd5:    v = 16'd2047;
            4'd6:    v = 16'd1024;
            4'd7:    v = 16'd512;
            4'd8:    v = 16'd256;
            4'd9:    v = 16'd128;
            4'd10:   v = 16'd64;
            4'd11:   v = 16'd32;
            4'd12:   v = 16'd16;
            4'd13:   v = 16'd8;
            4'd14:   v = 16'd4;
            default: v = 16'd2;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== design/axis_angle_vertex_rotator.sv =====
// An accepted vertex goes through the s1 register and then the output register.
// Throughput: one vertex per cycle once the matrix is built, while result_stall is low.
// Matrix set-up for a non-zero vector starts on each write to a rotation register and is
// paced by the builder's sequencer (square root, three 58-step divisions, CORDIC,
// nine entries); a zero vector, as after reset, skips these and sets pass-through.
// Reset (rst_n, asynchronous) clears the rotation registers and the pipeline valids.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module axis_angle_vertex_rotator #(
    parameter int MATRIX_FRAC_BITS = aavr_pkg::MATRIX_FRAC_BITS
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  vertex_valid,
    output logic                                       vertex_stall,
    input  wire aavr_pkg::vertex_t                     vertex,
    output logic                                       result_valid,
    input  wire logic                                  result_stall,
    output aavr_pkg::result_t                          result,
    input  wire logic                                  cfg_write_en,
    input  wire logic [aavr_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  wire logic [aavr_pkg::ROT_WIDTH-1:0]        cfg_data
);

    localparam int CW = aavr_pkg::COORD_WIDTH;
    localparam int MW = MATRIX_FRAC_BITS + 2;

    logic signed [aavr_pkg::ROT_WIDTH-1:0] rot_x_reg, rot_y_reg, rot_z_reg;
    logic                  restart;
    aavr_pkg::mat_status_t status;
    logic signed [MW-1:0]  matrix [9];
    logic                  en, accept;
    logic                  s1_valid_reg, s1_pass_reg;
    aavr_pkg::vertex_t     s1_vertex_reg;
    logic                  out_valid_reg;
    aavr_pkg::result_t     out_reg;
    logic signed [CW-1:0]  lane_result [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rot_x_reg <= '0;
            rot_y_reg <= '0;
            rot_z_reg <= '0;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                aavr_pkg::CFG_ROT_X: rot_x_reg <= cfg_data;
                aavr_pkg::CFG_ROT_Y: rot_y_reg <= cfg_data;
                aavr_pkg::CFG_ROT_Z: rot_z_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Writes beyond the last register leave the matrix as it is.
    assign restart = cfg_write_en && (cfg_index == aavr_pkg::CFG_ROT_X
                  || cfg_index == aavr_pkg::CFG_ROT_Y || cfg_index == aavr_pkg::CFG_ROT_Z);

    aavr_matrix_builder #(
        .MATRIX_FRAC_BITS(MATRIX_FRAC_BITS)
    ) u_builder (
        .clk     (clk),
        .rst_n   (rst_n),
        .restart (restart),
        .rot_x   (rot_x_reg),
        .rot_y   (rot_y_reg),
        .rot_z   (rot_z_reg),
        .status  (status),
        .matrix  (matrix)
    );

    assign en           = !out_valid_reg || !result_stall;
    assign vertex_stall = !en || !status.ready;
    assign accept       = vertex_valid && !vertex_stall;

    genvar g;
    generate
        for (g = 0; g < 3; g++)
        begin : g_lane
            aavr_lane #(
                .MATRIX_FRAC_BITS(MATRIX_FRAC_BITS)
            ) u_lane (
                .clk    (clk),
                .en     (en),
                .vertex (vertex),
                .m0     (matrix[g]),
                .m1     (matrix[3 + g]),
                .m2     (matrix[6 + g]),
                .result (lane_result[g])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg  <= accept;
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_vertex_reg <= vertex;
            s1_pass_reg   <= status.pass_through;
            if (s1_pass_reg)
            begin
                out_reg.out_x <= s1_vertex_reg.vertex_x;
                out_reg.out_y <= s1_vertex_reg.vertex_y;
                out_reg.out_z <= s1_vertex_reg.vertex_z;
            end
            else
            begin
                out_reg.out_x <= lane_result[0];
                out_reg.out_y <= lane_result[1];
                out_reg.out_z <= lane_result[2];
            end
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    `ASSERT_IMPLY(a_accept_needs_matrix, clk, rst_n, vertex_valid && !vertex_stall, status.ready)
    `ASSERT_NEXT(a_write_drops_matrix, clk, rst_n, restart, !status.ready)
    `ASSERT_NEXT(a_stage_holds, clk, rst_n, s1_valid_reg && !en, s1_valid_reg)

endmodule

`default_nettype wire

// ===== design/aavr_matrix_builder.sv =====
`timescale 1ns / 1ps
`default_nettype none

module aavr_matrix_builder #(
    parameter int MATRIX_FRAC_BITS = aavr_pkg::MATRIX_FRAC_BITS
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  restart,
    input  wire logic signed [aavr_pkg::ROT_WIDTH-1:0] rot_x,
    input  wire logic signed [aavr_pkg::ROT_WIDTH-1:0] rot_y,
    input  wire logic signed [aavr_pkg::ROT_WIDTH-1:0] rot_z,
    output aavr_pkg::mat_status_t                      status,
    output logic signed [MATRIX_FRAC_BITS+1:0]         matrix [9]
);

    localparam int MW = MATRIX_FRAC_BITS + 2;
    localparam int SH = 30 - MATRIX_FRAC_BITS;
    localparam logic signed [39:0] RND =
        (SH > 0) ? (40'sd1 <<< (SH - ((SH > 0) ? 1 : 0))) : 40'sd0;
    localparam logic signed [39:0] LIM = 40'sd1 <<< MATRIX_FRAC_BITS;
    localparam logic signed [28:0] PI_C      = 29'(aavr_pkg::PI_Q24);
    localparam logic signed [28:0] HALF_PI_C = 29'(aavr_pkg::HALF_PI_Q24);
    localparam logic signed [28:0] TWO_PI_C  = 29'(aavr_pkg::TWO_PI_Q24);
    localparam logic [3:0] LAST_STEP = 4'(aavr_pkg::CORDIC_STEPS - 1);

    typedef enum logic [3:0] {
        ST_IDLE, ST_SQ, ST_SQRT, ST_DIV, ST_MOD, ST_FOLD,
        ST_CORDIC, ST_TRIG, ST_KK, ST_E, ST_SK, ST_FIN
    } state_t;

    state_t             state_reg;
    logic               ready_reg;
    logic               pass_reg;
    logic [5:0]         cnt_reg;
    logic [1:0]         comp_reg;
    logic [39:0]        len2_reg;
    logic [55:0]        xs_reg, res_reg, one_reg;
    logic [27:0]        len24_reg;
    logic [57:0]        num_reg;
    logic [28:0]        rem_reg;
    logic signed [31:0] k_reg [3];
    logic signed [28:0] theta_reg;
    logic               flip_reg;
    logic signed [19:0] z_reg;
    logic signed [32:0] x_reg, y_reg, c_reg, s_reg;
    logic signed [33:0] omc_reg, kk_reg;
    logic signed [37:0] e_reg;
    logic signed [34:0] sk_reg;
    logic [1:0]         ei_reg, ej_reg;
    logic signed [MW-1:0] matrix_reg [9];

    logic signed [19:0] rsel;
    logic signed [39:0] sq;
    logic [39:0]        len2_next;
    logic [55:0]        trial, xs_next, res_next;
    logic [28:0]        rem_shift, rem_next;
    logic               qbit;
    logic [57:0]        num_next;
    logic [19:0]        mag_next;
    logic signed [28:0] t1, t2, zt;
    logic signed [32:0] x_next, y_next;
    logic signed [19:0] z_next, atan_s;
    logic [1:0]         m_idx;
    logic signed [63:0] kk_prod;
    logic signed [67:0] e_prod;
    logic signed [64:0] sk_prod;
    logic               minus;
    logic signed [39:0] fin_sum, fin_term, fin_rnd, fin_sat;
    logic [3:0]         widx;

    always_comb
    begin
        case (comp_reg)
            2'd0:    rsel = rot_x;
            2'd1:    rsel = rot_y;
            default: rsel = rot_z;
        endcase
        sq        = rsel * rsel;
        len2_next = len2_reg + $unsigned(sq);

        trial = res_reg + one_reg;
        if (xs_reg >= trial)
        begin
            xs_next  = xs_reg - trial;
            res_next = (res_reg >> 1) + one_reg;
        end
        else
        begin
            xs_next  = xs_reg;
            res_next = res_reg >> 1;
        end

        rem_shift = {rem_reg[27:0], num_reg[57]};
        qbit      = (rem_shift >= {1'b0, len24_reg});
        rem_next  = qbit ? rem_shift - {1'b0, len24_reg} : rem_shift;
        num_next  = {num_reg[56:0], qbit};
        mag_next  = rsel[19] ? 20'(-rsel) : 20'(rsel);

        t1 = (theta_reg > PI_C) ? theta_reg - TWO_PI_C : theta_reg;
        if (t1 > HALF_PI_C)
            t2 = PI_C - t1;
        else if (t1 < -HALF_PI_C)
            t2 = -PI_C - t1;
        else
            t2 = t1;
        zt = (t2 + 29'sd128) >>> 8;

        atan_s = $signed({4'b0, aavr_pkg::atan_q16(cnt_reg[3:0])});
        if (!z_reg[19])
        begin
            x_next = x_reg - (y_reg >>> cnt_reg[3:0]);
            y_next = y_reg + (x_reg >>> cnt_reg[3:0]);
            z_next = z_reg - atan_s;
        end
        else
        begin
            x_next = x_reg + (y_reg >>> cnt_reg[3:0]);
            y_next = y_reg - (x_reg >>> cnt_reg[3:0]);
            z_next = z_reg + atan_s;
        end

        m_idx   = 2'd3 - ei_reg - ej_reg;
        kk_prod = k_reg[ei_reg] * k_reg[ej_reg];
        e_prod  = omc_reg * kk_reg;
        sk_prod = s_reg * k_reg[m_idx];

        // The entry just above the diagonal, cyclically, takes minus s*k.
        minus = (ei_reg == 2'd0 && ej_reg == 2'd1) || (ei_reg == 2'd1 && ej_reg == 2'd2)
             || (ei_reg == 2'd2 && ej_reg == 2'd0);
        if (ei_reg == ej_reg)
            fin_term = 40'(c_reg);
        else if (minus)
            fin_term = -40'(sk_reg);
        else
            fin_term = 40'(sk_reg);
        fin_sum = 40'(e_reg) + fin_term;
        fin_rnd = (fin_sum + RND) >>> SH;
        if (fin_rnd > LIM)
            fin_sat = LIM;
        else if (fin_rnd < -LIM)
            fin_sat = -LIM;
        else
            fin_sat = fin_rnd;
        widx = 4'({2'b0, ei_reg} * 4'd3 + {2'b0, ej_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ready_reg <= 1'b0;
            pass_reg  <= 1'b0;
        end
        else if (restart)
        begin
            state_reg <= ST_IDLE;
            ready_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (!ready_reg)
                    begin
                        state_reg <= ST_SQ;
                        comp_reg  <= 2'd0;
                        len2_reg  <= '0;
                    end
                end
                ST_SQ:
                begin
                    len2_reg <= len2_next;
                    if (comp_reg == 2'd2)
                    begin
                        if (len2_next == '0)
                        begin
                            pass_reg  <= 1'b1;
                            ready_reg <= 1'b1;
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            pass_reg  <= 1'b0;
                            xs_reg    <= {len2_next, 16'b0};
                            res_reg   <= '0;
                            one_reg   <= 56'd1 << 54;
                            state_reg <= ST_SQRT;
                        end
                    end
                    else
                        comp_reg <= comp_reg + 2'd1;
                end
                ST_SQRT:
                begin
                    xs_reg  <= xs_next;
                    res_reg <= res_next;
                    one_reg <= one_reg >> 2;
                    if (one_reg[0])
                    begin
                        len24_reg <= res_next[27:0];
                        comp_reg  <= 2'd0;
                        rem_reg   <= '0;
                        num_reg   <= {(rot_x[19] ? 20'(-rot_x) : 20'(rot_x)), 38'b0};
                        cnt_reg   <= '0;
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    rem_reg <= rem_next;
                    num_reg <= num_next;
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd57)
                    begin
                        k_reg[comp_reg] <= rsel[19] ? -$signed({1'b0, num_next[30:0]})
                                                    : $signed({1'b0, num_next[30:0]});
                        cnt_reg <= '0;
                        rem_reg <= '0;
                        if (comp_reg == 2'd2)
                        begin
                            theta_reg <= $signed({1'b0, len24_reg});
                            state_reg <= ST_MOD;
                        end
                        else
                        begin
                            comp_reg <= comp_reg + 2'd1;
                            // Operand of the next component is loaded in the extra cnt_reg == 6'h3f step.
                            state_reg <= ST_DIV;
                            num_reg   <= '0;
                            cnt_reg   <= 6'h3f;
                        end
                    end
                    else if (cnt_reg == 6'h3f)
                    begin
                        num_reg <= {mag_next, 38'b0};
                        rem_reg <= '0;
                        cnt_reg <= '0;
                    end
                end
                ST_MOD:
                begin
                    if (theta_reg >= TWO_PI_C)
                        theta_reg <= theta_reg - TWO_PI_C;
                    else
                        state_reg <= ST_FOLD;
                end
                ST_FOLD:
                begin
                    flip_reg  <= (t1 > HALF_PI_C) || (t1 < -HALF_PI_C);
                    z_reg     <= zt[19:0];
                    x_reg     <= 33'(aavr_pkg::CORDIC_GAIN);
                    y_reg     <= '0;
                    cnt_reg   <= '0;
                    state_reg <= ST_CORDIC;
                end
                ST_CORDIC:
                begin
                    x_reg   <= x_next;
                    y_reg   <= y_next;
                    z_reg   <= z_next;
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg[3:0] == LAST_STEP)
                        state_reg <= ST_TRIG;
                end
                ST_TRIG:
                begin
                    c_reg     <= flip_reg ? -x_reg : x_reg;
                    s_reg     <= y_reg;
                    omc_reg   <= (34'sd1 <<< 30) - (flip_reg ? -34'(x_reg) : 34'(x_reg));
                    ei_reg    <= 2'd0;
                    ej_reg    <= 2'd0;
                    state_reg <= ST_KK;
                end
                ST_KK:
                begin
                    kk_reg    <= kk_prod[63:30];
                    state_reg <= ST_E;
                end
                ST_E:
                begin
                    e_reg     <= e_prod[67:30];
                    state_reg <= ST_SK;
                end
                ST_SK:
                begin
                    sk_reg    <= sk_prod[64:30];
                    state_reg <= ST_FIN;
                end
                ST_FIN:
                begin
                    matrix_reg[widx] <= fin_sat[MW-1:0];
                    state_reg        <= ST_KK;
                    if (ej_reg == 2'd2)
                    begin
                        ej_reg <= 2'd0;
                        if (ei_reg == 2'd2)
                        begin
                            ready_reg <= 1'b1;
                            state_reg <= ST_IDLE;
                        end
                        else
                            ei_reg <= ei_reg + 2'd1;
                    end
                    else
                        ej_reg <= ej_reg + 2'd1;
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    assign status.ready        = ready_reg;
    assign status.pass_through = pass_reg;
    assign matrix              = matrix_reg;

endmodule

`default_nettype wire

// ===== design/aavr_lane.sv =====
`timescale 1ns / 1ps
`default_nettype none

module aavr_lane #(
    parameter int MATRIX_FRAC_BITS = aavr_pkg::MATRIX_FRAC_BITS
) (
    input  wire logic                                    clk,
    input  wire logic                                    en,
    input  wire aavr_pkg::vertex_t                       vertex,
    input  wire logic signed [MATRIX_FRAC_BITS+1:0]      m0,
    input  wire logic signed [MATRIX_FRAC_BITS+1:0]      m1,
    input  wire logic signed [MATRIX_FRAC_BITS+1:0]      m2,
    output logic signed [aavr_pkg::COORD_WIDTH-1:0]      result
);

    localparam int CW = aavr_pkg::COORD_WIDTH;
    localparam int MW = MATRIX_FRAC_BITS + 2;
    localparam int PW = CW + MW;
    localparam int SW = PW + 2;
    localparam logic signed [SW-1:0] RND  = {{(SW-1){1'b0}}, 1'b1} << (MATRIX_FRAC_BITS - 1);
    localparam logic signed [SW-1:0] MAXV = {{(SW-CW+1){1'b0}}, {(CW-1){1'b1}}};
    localparam logic signed [SW-1:0] MINV = ~MAXV;

    logic signed [PW-1:0] p0_reg, p1_reg, p2_reg;
    logic signed [SW-1:0] acc, shifted;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p0_reg <= vertex.vertex_x * m0;
            p1_reg <= vertex.vertex_y * m1;
            p2_reg <= vertex.vertex_z * m2;
        end
    end

    always_comb
    begin
        acc     = SW'(p0_reg) + SW'(p1_reg) + SW'(p2_reg) + RND;
        shifted = acc >>> MATRIX_FRAC_BITS;
        if (shifted > MAXV)
            result = MAXV[CW-1:0];
        else if (shifted < MINV)
            result = MINV[CW-1:0];
        else
            result = shifted[CW-1:0];
    end

endmodule

`default_nettype wire

// ===== bench/tb_axis_angle_vertex_rotator.sv =====
`timescale 1ns / 1ps

module tb_axis_angle_vertex_rotator;

    localparam logic [aavr_pkg::CFG_INDEX_WIDTH-1:0] CFG_UNUSED = 2'd3;
    localparam int  STALL_LIMIT = 5000;
    localparam int  LONG_HOLD   = 400;
    localparam int  TRIG_Q      = 30;
    localparam int  ENTRY_SHIFT = TRIG_Q - aavr_pkg::MATRIX_FRAC_BITS;
    localparam longint ENTRY_LIM = longint'(1) << aavr_pkg::MATRIX_FRAC_BITS;
    localparam longint COORD_MAX = (longint'(1) << (aavr_pkg::COORD_WIDTH - 1)) - 1;
    localparam longint COORD_MIN = -(longint'(1) << (aavr_pkg::COORD_WIDTH - 1));

    logic                 clk;
    logic                 rst_n;
    logic                 vertex_valid;
    logic                 vertex_stall;
    aavr_pkg::vertex_t    vertex;
    logic                 result_valid;
    logic                 result_stall;
    aavr_pkg::result_t    result;
    logic                 cfg_write_en;
    logic [aavr_pkg::CFG_INDEX_WIDTH-1:0] cfg_index;
    logic [aavr_pkg::ROT_WIDTH-1:0]       cfg_data;

    axis_angle_vertex_rotator DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .vertex_valid (vertex_valid),
        .vertex_stall (vertex_stall),
        .vertex       (vertex),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // Arctangent of 2^-i in Q.16, one entry per CORDIC step.
    longint arc_step [aavr_pkg::CORDIC_STEPS] = '{
        51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
        256, 128, 64, 32, 16, 8, 4, 2
    };

    logic signed [aavr_pkg::ROT_WIDTH-1:0] rot_vec [3];
    longint  rot_entry [9];
    bit      rot_built;
    bit      rot_identity;

    aavr_pkg::result_t expected_rotations [$];
    int      fail_count;
    int      vertices_sent;
    int      rotations_seen;
    int      reg_writes;
    int      settings_used;
    int      sender_idle_pct;
    int      receiver_idle_pct;
    int      hold_requests;
    bit      run_done;

    typedef struct {
        aavr_pkg::vertex_t v;
        bit                typed;
        aavr_pkg::result_t r;
    } stim_row_t;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    function automatic longint unsigned root_floor(input longint unsigned x);
        longint unsigned res;
        longint unsigned one;
        res = 0;
        one = longint'(1) << 62;
        while (one > x)
            one = one >> 2;
        while (one != 0)
        begin
            if (x >= res + one)
            begin
                x   = x - (res + one);
                res = (res >> 1) + one;
            end
            else
                res = res >> 1;
            one = one >> 2;
        end
        return res;
    endfunction

    function automatic void build_rotation();
        longint r [3];
        longint k [3];
        longint unsigned len2;
        longint unsigned len24;
        longint unsigned q;
        longint theta, z, x, y, dx, dy, c, s, omc, kk, e, sk;
        bit flip;
        r[0] = rot_vec[0];
        r[1] = rot_vec[1];
        r[2] = rot_vec[2];
        len2 = r[0] * r[0] + r[1] * r[1] + r[2] * r[2];
        rot_built = 1'b1;
        rot_identity = (len2 == 0);
        if (rot_identity)
            return;
        len24 = root_floor(len2 << 16);
        for (int i = 0; i < 3; i++)
        begin
            q = (longint'(r[i] < 0 ? -r[i] : r[i]) << 38) / len24;
            k[i] = r[i] < 0 ? -longint'(q) : longint'(q);
        end
        // Reduce the angle to (-pi, pi] and fold it into the CORDIC's reach.
        flip = 1'b0;
        theta = longint'(len24 % aavr_pkg::TWO_PI_Q24);
        if (theta > aavr_pkg::PI_Q24)
            theta = theta - aavr_pkg::TWO_PI_Q24;
        if (theta > aavr_pkg::HALF_PI_Q24)
        begin
            theta = aavr_pkg::PI_Q24 - theta;
            flip  = 1'b1;
        end
        else if (theta < -aavr_pkg::HALF_PI_Q24)
        begin
            theta = -aavr_pkg::PI_Q24 - theta;
            flip  = 1'b1;
        end
        z = (theta + 128) >>> 8;
        x = aavr_pkg::CORDIC_GAIN;
        y = 0;
        for (int i = 0; i < aavr_pkg::CORDIC_STEPS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - arc_step[i];
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + arc_step[i];
            end
        end
        c = flip ? -x : x;
        s = y;
        omc = (longint'(1) << TRIG_Q) - c;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                kk = (k[i] * k[j]) >>> TRIG_Q;
                e  = (omc * kk) >>> TRIG_Q;
                if (i == j)
                    e = e + c;
                else
                begin
                    sk = (s * k[3 - i - j]) >>> TRIG_Q;
                    if ((j + 3 - i) % 3 == 1)
                        e = e - sk;
                    else
                        e = e + sk;
                end
                e = (e + (longint'(1) << (ENTRY_SHIFT - 1))) >>> ENTRY_SHIFT;
                if (e > ENTRY_LIM)
                    e = ENTRY_LIM;
                if (e < -ENTRY_LIM)
                    e = -ENTRY_LIM;
                rot_entry[i * 3 + j] = e;
            end
        end
    endfunction

    function automatic aavr_pkg::result_t rotate_vertex(input aavr_pkg::vertex_t v);
        longint  vin [3];
        longint  acc;
        logic signed [aavr_pkg::COORD_WIDTH-1:0] outc [3];
        aavr_pkg::result_t r;
        if (!rot_built)
            build_rotation();
        vin[0] = v.vertex_x;
        vin[1] = v.vertex_y;
        vin[2] = v.vertex_z;
        for (int j = 0; j < 3; j++)
        begin
            if (rot_identity)
                outc[j] = vin[j];
            else
            begin
                acc = longint'(1) << (aavr_pkg::MATRIX_FRAC_BITS - 1);
                for (int i = 0; i < 3; i++)
                    acc = acc + vin[i] * rot_entry[i * 3 + j];
                acc = acc >>> aavr_pkg::MATRIX_FRAC_BITS;
                if (acc > COORD_MAX)
                    acc = COORD_MAX;
                if (acc < COORD_MIN)
                    acc = COORD_MIN;
                outc[j] = acc;
            end
        end
        r.out_x = outc[0];
        r.out_y = outc[1];
        r.out_z = outc[2];
        return r;
    endfunction

    // Offers one word and returns at the edge that takes it, valid still high.
    task automatic send_vertex(input aavr_pkg::vertex_t v, input bit typed,
                               input aavr_pkg::result_t r);
        aavr_pkg::result_t predicted;
        vertex_valid <= 1'b1;
        vertex       <= v;
        @(posedge clk);
        while (vertex_stall)
            @(posedge clk);
        predicted = rotate_vertex(v);
        expected_rotations.push_back(typed ? r : predicted);
        vertices_sent++;
    endtask

    // Each cycle between words is idle with the sender's idle share.
    task automatic maybe_pause();
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            vertex_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    // Drops valid and waits until every rotated word has come back.
    task automatic drain();
        vertex_valid <= 1'b0;
        @(posedge clk);
        while (expected_rotations.size() != 0)
            @(posedge clk);
        repeat (4)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [aavr_pkg::CFG_INDEX_WIDTH-1:0] idx,
                             input logic [aavr_pkg::ROT_WIDTH-1:0] val);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= val;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        if (idx != CFG_UNUSED)
        begin
            rot_vec[idx] = val;
            rot_built    = 1'b0;
        end
        reg_writes++;
    endtask

    task automatic set_rotation(input logic [aavr_pkg::ROT_WIDTH-1:0] rx,
                                input logic [aavr_pkg::ROT_WIDTH-1:0] ry,
                                input logic [aavr_pkg::ROT_WIDTH-1:0] rz);
        write_reg(aavr_pkg::CFG_ROT_X, rx);
        write_reg(aavr_pkg::CFG_ROT_Y, ry);
        write_reg(aavr_pkg::CFG_ROT_Z, rz);
        settings_used++;
    endtask

    function automatic logic [aavr_pkg::ROT_WIDTH-1:0] random_component();
        logic signed [aavr_pkg::ROT_WIDTH-1:0] c;
        c = $urandom;
        if ($urandom_range(0, 3) == 0)
            c = $signed($urandom_range(0, 4000)) - 2000;
        return c;
    endfunction

    function automatic logic [aavr_pkg::COORD_WIDTH-1:0] random_coord();
        logic signed [aavr_pkg::COORD_WIDTH-1:0] c;
        c = $urandom;
        if ($urandom_range(0, 3) != 0)
            c = c >>> $urandom_range(4, 16);
        return c;
    endfunction

    task automatic send_random(input int count);
        aavr_pkg::vertex_t v;
        aavr_pkg::result_t none;
        none = '0;
        for (int n = 0; n < count; n++)
        begin
            v.vertex_x = random_coord();
            v.vertex_y = random_coord();
            v.vertex_z = random_coord();
            send_vertex(v, 1'b0, none);
            maybe_pause();
        end
    endtask

    // Result side: random stalls, plus a long hold whenever one is asked for.
    initial
    begin
        int holds_done;
        int hold_left;
        holds_done = 0;
        hold_left  = 0;
        result_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_requests != holds_done)
            begin
                holds_done = hold_requests;
                hold_left  = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else
                result_stall <= ($urandom_range(0, 99) < receiver_idle_pct);
        end
    end

    // Compares every word taken from the block with the oldest prediction.
    initial
    begin
        aavr_pkg::result_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_valid && !result_stall)
            begin
                rotations_seen++;
                if (expected_rotations.size() == 0)
                begin
                    $display("%0t: unexpected word, actual %h", $time, result);
                    fail_count++;
                end
                else
                begin
                    want = expected_rotations.pop_front();
                    if (result.out_x !== want.out_x)
                    begin
                        $display("%0t: out_x expected %h actual %h", $time, want.out_x,
                                 result.out_x);
                        fail_count++;
                    end
                    if (result.out_y !== want.out_y)
                    begin
                        $display("%0t: out_y expected %h actual %h", $time, want.out_y,
                                 result.out_y);
                        fail_count++;
                    end
                    if (result.out_z !== want.out_z)
                    begin
                        $display("%0t: out_z expected %h actual %h", $time, want.out_z,
                                 result.out_z);
                        fail_count++;
                    end
                end
            end
        end
    end

    // Ends the run if nothing moves on either side for too long.
    initial
    begin
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((vertex_valid && !vertex_stall) || (result_valid && !result_stall)
                || cfg_write_en || run_done)
                quiet = 0;
            else
                quiet++;
            if (quiet >= STALL_LIMIT)
            begin
                $display("tb_axis_angle_vertex_rotator failed");
                $finish;
            end
        end
    end

    initial
    begin
        stim_row_t plain_rows [$];
        stim_row_t turned_rows [$];
        stim_row_t row;
        aavr_pkg::vertex_t v;
        fail_count = 0;
        vertices_sent = 0;
        rotations_seen = 0;
        reg_writes = 0;
        settings_used = 0;
        hold_requests = 0;
        run_done = 1'b0;
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
        rot_vec[0] = '0;
        rot_vec[1] = '0;
        rot_vec[2] = '0;
        rot_built = 1'b0;
        rot_identity = 1'b0;
        rst_n = 1'b0;
        vertex_valid = 1'b0;
        vertex = '0;
        cfg_write_en = 1'b0;
        cfg_index = aavr_pkg::CFG_ROT_X;
        cfg_data = '0;

        // With a zero rotation vector every word passes through untouched.
        v = {32'h7fffffff, 32'h80000000, 32'h00000000};
        plain_rows.push_back('{v, 1'b1, aavr_pkg::result_t'(v)});
        v = {32'h80000000, 32'h7fffffff, 32'hffffffff};
        plain_rows.push_back('{v, 1'b1, aavr_pkg::result_t'(v)});
        v = {32'h00010000, 32'hfffe0000, 32'h00000001};
        plain_rows.push_back('{v, 1'b1, aavr_pkg::result_t'(v)});
        v = {32'h55555555, 32'haaaaaaaa, 32'h12345678};
        plain_rows.push_back('{v, 1'b1, aavr_pkg::result_t'(v)});

        // Extremes of the coordinates; large vectors saturate after turning.
        v = {32'h7fffffff, 32'h7fffffff, 32'h7fffffff};
        turned_rows.push_back('{v, 1'b0, '0});
        v = {32'h80000000, 32'h80000000, 32'h80000000};
        turned_rows.push_back('{v, 1'b0, '0});
        v = {32'h7fffffff, 32'h80000000, 32'h7fffffff};
        turned_rows.push_back('{v, 1'b0, '0});
        v = {32'h00010000, 32'h00000000, 32'h00000000};
        turned_rows.push_back('{v, 1'b0, '0});
        v = {32'h00000000, 32'hffff0000, 32'h00020000};
        turned_rows.push_back('{v, 1'b0, '0});
        v = '0;
        turned_rows.push_back('{v, 1'b0, '0});

        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plain_rows[i])
        begin
            row = plain_rows[i];
            send_vertex(row.v, row.typed, row.r);
        end
        drain();
        // A write past the last register changes nothing.
        write_reg(CFG_UNUSED, 20'h12345);
        foreach (plain_rows[i])
        begin
            row = plain_rows[i];
            send_vertex(row.v, row.typed, row.r);
        end
        drain();
        set_rotation(20'h7ffff, 20'h00000, 20'h80000);
        foreach (turned_rows[i])
        begin
            row = turned_rows[i];
            send_vertex(row.v, row.typed, row.r);
        end
        drain();
        // A quarter turn about z.
        set_rotation(20'h00000, 20'h00000, 20'd102944);
        foreach (turned_rows[i])
        begin
            row = turned_rows[i];
            send_vertex(row.v, row.typed, row.r);
        end
        drain();

        for (int phase = 0; phase < 3; phase++)
        begin
            sender_idle_pct   = (phase == 0) ? 38 : (phase == 1) ? 54 : 0;
            receiver_idle_pct = (phase == 0) ? 54 : (phase == 1) ? 38 : 0;
            for (int s = 0; s < 4; s++)
            begin
                if (phase == 0 && s == 0)
                    set_rotation(20'h7ffff, 20'h7ffff, 20'h7ffff);
                else if (phase == 0 && s == 1)
                    set_rotation(20'h80000, 20'h80000, 20'h80000);
                else if (phase == 2 && s == 0)
                    set_rotation('0, '0, '0);
                else
                    set_rotation(random_component(), random_component(),
                                 random_component());
                if (phase == 1 && s == 2)
                    hold_requests++;
                send_random(40);
                // On the second setting of each phase the sender waits here until every word is back.
                if (s == 1)
                    drain();
                send_random(43);
                drain();
            end
        end

        run_done = 1'b1;
        repeat (20)
            @(posedge clk);
        $display("Sent %0d vertices over %0d rotation settings (%0d register writes),",
                 vertices_sent, settings_used, reg_writes);
        $display("checked %0d rotated words under three stall patterns.", rotations_seen);
        if (fail_count == 0 && expected_rotations.size() == 0)
            $display("tb_axis_angle_vertex_rotator passed");
        else
            $display("tb_axis_angle_vertex_rotator failed");
        $finish;
    end

endmodule
